[rtl/glvs_pkg.sv]
// ----------------------------------------------------------------------------
// glvs_pkg
// Shared types and constants of the gesture label vote stabilizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glvs_pkg;

  typedef struct packed {
    logic               mode;
    logic [31:0]        time_ms;
    logic [7:0]         candidate;
    logic signed [15:0] confidence;
    logic               signal_ok;
  } glvs_in_t;

  typedef struct packed {
    logic [31:0]        frame_count;
    logic [31:0]        change_count;
    logic [7:0]         gesture;
    logic [1:0]         validity;
    logic signed [15:0] margin_echo;
    logic [31:0]        time_echo;
    logic [7:0]         candidate_echo;
  } glvs_out_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DIV_W      = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LABEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOTE_HORIZON = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_FRACTION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME    = 3'd5;

  // register reset values
  localparam logic [7:0]         RST_REST_LABEL   = 8'd0;
  localparam logic [15:0]        RST_VOTE_HORIZON = 16'd200;
  localparam logic [15:0]        RST_NOMINAL_STEP = 16'd20;
  localparam logic [16:0]        RST_REQ_FRACTION = 17'd39322;
  localparam logic signed [15:0] RST_MARGIN_THR   = 16'sd128;
  localparam logic [15:0]        RST_HOLD_TIME    = 16'd100;

  // validity codes
  localparam logic [1:0] VAL_OK      = 2'd0;
  localparam logic [1:0] VAL_SIGNAL  = 2'd1;
  localparam logic [1:0] VAL_LOWCONF = 2'd2;

endpackage

[rtl/gesture_label_vote_stabilizer.sv]
// ----------------------------------------------------------------------------
// gesture_label_vote_stabilizer
// Turns timestamped classifier labels into a stable gesture label using a
// time-limited vote window held in a small dual-read memory.
// ----------------------------------------------------------------------------
//
//   channel | signals                              | transfer when
//   --------+--------------------------------------+---------------------------
//   in      | in_valid_i, in_stall_o, in_data_i    | in_valid_i & !in_stall_o
//   out     | out_valid_o, out_stall_i, out_data_o | out_valid_o & !out_stall_i
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | valid & ready
//
// One frame at a time. A voting frame walks the window once, packing the
// young votes toward the front, and runs the min-count divider. When the
// election has matured it also scans pairs of the held votes on the two
// memory read ports, stopping at the first label that holds the fraction.
// The result sits in an output register, so the next frame is taken while
// it waits on out_stall_i. Reset is asynchronous and clears all state; the
// vote memory needs no clearing since only held entries are read.
`timescale 1ns / 1ps

module gesture_label_vote_stabilizer #(
  parameter int VOTE_DEPTH = 16,
  parameter int LABEL_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  glvs_pkg::glvs_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output glvs_pkg::glvs_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [glvs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [glvs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LW    = LABEL_BITS;
  localparam int AW    = $clog2(VOTE_DEPTH);
  localparam int CNT_W = $clog2(VOTE_DEPTH + 1);
  localparam int EW    = 32 + LW;
  localparam int PW    = 17 + CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_CRD  = 4'd2;
  localparam logic [3:0] S_CWR  = 4'd3;
  localparam logic [3:0] S_CAPP = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_MAT  = 4'd6;
  localparam logic [3:0] S_MI   = 4'd7;
  localparam logic [3:0] S_MJ   = 4'd8;
  localparam logic [3:0] S_MCHK = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  // configuration registers
  logic [7:0]         rest_q;
  logic [15:0]        horizon_q;
  logic [15:0]        step_q;
  logic [16:0]        frac_q;
  logic signed [15:0] thr_q;
  logic [15:0]        hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q    <= glvs_pkg::RST_REST_LABEL;
      horizon_q <= glvs_pkg::RST_VOTE_HORIZON;
      step_q    <= glvs_pkg::RST_NOMINAL_STEP;
      frac_q    <= glvs_pkg::RST_REQ_FRACTION;
      thr_q     <= glvs_pkg::RST_MARGIN_THR;
      hold_q    <= glvs_pkg::RST_HOLD_TIME;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        glvs_pkg::CFG_REST_LABEL:   rest_q    <= cfg_data_i[7:0];
        glvs_pkg::CFG_VOTE_HORIZON: horizon_q <= cfg_data_i[15:0];
        glvs_pkg::CFG_NOMINAL_STEP: step_q    <= cfg_data_i[15:0];
        glvs_pkg::CFG_REQ_FRACTION: frac_q    <= cfg_data_i;
        glvs_pkg::CFG_MARGIN_THR:   thr_q     <= cfg_data_i[15:0];
        glvs_pkg::CFG_HOLD_TIME:    hold_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic [3:0]          state_q, state_d;
  glvs_pkg::glvs_in_t  item_q, item_d;
  logic [31:0]         frames_q, frames_d;
  logic [31:0]         changes_q, changes_d;
  logic [LW-1:0]       stable_q, stable_d;
  logic [31:0]         ptime_q, ptime_d;
  logic                ptk_q, ptk_d;
  logic [31:0]         ctime_q, ctime_d;
  logic                cknown_q, cknown_d;
  logic [31:0]         etime_q, etime_d;
  logic                eopen_q, eopen_d;
  logic [CNT_W-1:0]    held_q, held_d;
  logic [LW-1:0]       pgest_q, pgest_d;
  logic [1:0]          pval_q, pval_d;
  logic [CNT_W-1:0]    r_q, r_d, w_q, w_d, i_q, i_d, j_q, j_d, cnt_q, cnt_d;
  logic                pv_q, pv_d;
  logic [PW-1:0]       prod_q, prod_d;
  logic [16:0]         minc_q, minc_d;
  logic [LW-1:0]       eg_q, eg_d;
  logic [1:0]          ev_q, ev_d;
  glvs_pkg::glvs_out_t out_q, out_d;
  logic                ovalid_q, ovalid_d;

  // memory and divider hookup
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;
  logic [AW-1:0]     ra_addr;
  logic [EW-1:0]     ra_data;
  logic [AW-1:0]     rb_addr;
  logic [EW-1:0]     rb_data;
  logic              div_start;
  logic              div_done;
  logic [15:0]       div_quot;
  logic [15:0]       div_divisor;

  logic [31:0]       t;
  logic [LW-1:0]     cand;
  logic [LW-1:0]     rest;
  logic              hold_ok;
  logic [LW-1:0]     la;

  assign t    = item_q.time_ms;
  assign cand = LW'(item_q.candidate);
  assign rest = LW'(rest_q);
  assign la   = ra_data[LW-1:0];
  assign hold_ok = cknown_q && ((t - ctime_q) <= {16'h0, hold_q});
  assign div_divisor = (step_q == 16'h0) ? 16'd1 : step_q;

  assign ra_addr = (state_q == S_CRD) ? r_q[AW-1:0] : i_q[AW-1:0];
  assign rb_addr = j_q[AW-1:0];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  glvs_vote_mem #(
    .DEPTH (VOTE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (ra_addr),
    .rdata_a_o (ra_data),
    .raddr_b_i (rb_addr),
    .rdata_b_o (rb_data)
  );

  glvs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (horizon_q),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    frames_d  = frames_q;
    changes_d = changes_q;
    stable_d  = stable_q;
    ptime_d   = ptime_q;
    ptk_d     = ptk_q;
    ctime_d   = ctime_q;
    cknown_d  = cknown_q;
    etime_d   = etime_q;
    eopen_d   = eopen_q;
    held_d    = held_q;
    pgest_d   = pgest_q;
    pval_d    = pval_q;
    r_d       = r_q;
    w_d       = w_q;
    i_d       = i_q;
    j_d       = j_q;
    cnt_d     = cnt_q;
    pv_d      = pv_q;
    prod_d    = prod_q;
    minc_d    = minc_q;
    eg_d      = eg_q;
    ev_d      = ev_q;
    out_d     = out_q;
    ovalid_d  = ovalid_q && out_stall_i;
    mem_we    = 1'b0;
    mem_waddr = w_q[AW-1:0];
    mem_wdata = ra_data;
    div_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (item_q.mode) begin
          // continuity reset: back to rest, no result
          held_d   = '0;
          eopen_d  = 1'b0;
          stable_d = rest;
          cknown_d = 1'b0;
          ptk_d    = 1'b0;
          pgest_d  = rest;
          pval_d   = glvs_pkg::VAL_OK;
          state_d  = S_IDLE;
        end else begin
          frames_d = frames_q + 32'd1;
          if (ptk_q && (t < ptime_q)) begin
            // time ran backwards; prev time is kept
            held_d   = '0;
            eopen_d  = 1'b0;
            stable_d = rest;
            cknown_d = 1'b0;
            ptk_d    = 1'b0;
            eg_d     = rest;
            ev_d     = glvs_pkg::VAL_SIGNAL;
            state_d  = S_EMIT;
          end else begin
            ptime_d = t;
            ptk_d   = 1'b1;
            if (!item_q.signal_ok) begin
              held_d   = '0;
              eopen_d  = 1'b0;
              stable_d = rest;
              cknown_d = 1'b0;
              eg_d     = rest;
              ev_d     = glvs_pkg::VAL_SIGNAL;
              state_d  = S_EMIT;
            end else if (item_q.confidence < thr_q) begin
              // low confidence: keep the label only inside the hold window
              if (!hold_ok) begin
                held_d   = '0;
                eopen_d  = 1'b0;
                stable_d = rest;
                cknown_d = 1'b0;
              end
              eg_d    = hold_ok ? stable_q : rest;
              ev_d    = glvs_pkg::VAL_LOWCONF;
              state_d = S_EMIT;
            end else begin
              ctime_d  = t;
              cknown_d = 1'b1;
              if (!eopen_q) begin
                etime_d = t;
                eopen_d = 1'b1;
              end
              r_d     = '0;
              w_d     = '0;
              state_d = S_CRD;
            end
          end
        end
      end
      S_CRD: begin
        state_d = (r_q == held_q) ? S_CAPP : S_CWR;
      end
      S_CWR: begin
        // keep a vote that is still young enough, packed toward the front
        if ((t - ra_data[EW-1:LW]) <= {16'h0, horizon_q}) begin
          mem_we = 1'b1;
          w_d    = w_q + CNT_W'(1);
        end
        r_d     = r_q + CNT_W'(1);
        state_d = S_CRD;
      end
      S_CAPP: begin
        if (w_q < CNT_W'(VOTE_DEPTH)) begin
          mem_we    = 1'b1;
          mem_wdata = {t, cand};
          held_d    = w_q + CNT_W'(1);
        end else begin
          held_d = w_q;
        end
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          minc_d  = {1'b0, div_quot} + 17'd1;
          state_d = S_MAT;
        end
      end
      S_MAT: begin
        if ((17'(held_q) >= minc_q) && ((t - etime_q) >= {16'h0, horizon_q})) begin
          prod_d  = PW'(frac_q) * PW'(held_q);
          i_d     = '0;
          state_d = S_MI;
        end else begin
          eg_d    = stable_q;
          ev_d    = glvs_pkg::VAL_OK;
          state_d = S_EMIT;
        end
      end
      S_MI: begin
        j_d     = '0;
        pv_d    = 1'b0;
        cnt_d   = '0;
        state_d = S_MJ;
      end
      S_MJ: begin
        // port B streams every held label past entry i on port A
        if (j_q < held_q) begin
          j_d  = j_q + CNT_W'(1);
          pv_d = 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q && (rb_data[LW-1:0] == la)) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if ((j_q == held_q) && !pv_q) begin
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if (PW'({cnt_q, 16'h0}) >= prod_q) begin
          stable_d = la;
          eg_d     = la;
          ev_d     = glvs_pkg::VAL_OK;
          state_d  = S_EMIT;
        end else if ((i_q + CNT_W'(1)) == held_q) begin
          eg_d    = stable_q;
          ev_d    = glvs_pkg::VAL_OK;
          state_d = S_EMIT;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_MI;
        end
      end
      S_EMIT: begin
        if (!ovalid_q || !out_stall_i) begin
          changes_d = ((eg_q != pgest_q) || (ev_q != pval_q)) ?
                      changes_q + 32'd1 : changes_q;
          pgest_d   = eg_q;
          pval_d    = ev_q;
          out_d.frame_count    = frames_q;
          out_d.change_count   = changes_d;
          out_d.gesture        = 8'(eg_q);
          out_d.validity       = ev_q;
          out_d.margin_echo    = item_q.confidence;
          out_d.time_echo      = item_q.time_ms;
          out_d.candidate_echo = item_q.candidate;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      item_q    <= '0;
      frames_q  <= '0;
      changes_q <= '0;
      stable_q  <= LW'(glvs_pkg::RST_REST_LABEL);
      ptime_q   <= '0;
      ptk_q     <= 1'b0;
      ctime_q   <= '0;
      cknown_q  <= 1'b0;
      etime_q   <= '0;
      eopen_q   <= 1'b0;
      held_q    <= '0;
      pgest_q   <= LW'(glvs_pkg::RST_REST_LABEL);
      pval_q    <= glvs_pkg::VAL_OK;
      r_q       <= '0;
      w_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      prod_q    <= '0;
      minc_q    <= '0;
      eg_q      <= '0;
      ev_q      <= glvs_pkg::VAL_OK;
      out_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      item_q    <= item_d;
      frames_q  <= frames_d;
      changes_q <= changes_d;
      stable_q  <= stable_d;
      ptime_q   <= ptime_d;
      ptk_q     <= ptk_d;
      ctime_q   <= ctime_d;
      cknown_q  <= cknown_d;
      etime_q   <= etime_d;
      eopen_q   <= eopen_d;
      held_q    <= held_d;
      pgest_q   <= pgest_d;
      pval_q    <= pval_d;
      r_q       <= r_d;
      w_q       <= w_d;
      i_q       <= i_d;
      j_q       <= j_d;
      cnt_q     <= cnt_d;
      pv_q      <= pv_d;
      prod_q    <= prod_d;
      minc_q    <= minc_d;
      eg_q      <= eg_d;
      ev_q      <= ev_d;
      out_q     <= out_d;
      ovalid_q  <= ovalid_d;
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(VOTE_DEPTH))
    else $error("vote count above window depth");

  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MJ || state_q == S_MCHK) |-> (i_q < held_q))
    else $error("majority scan past held votes");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DEC))
    else $error("accepted frame not decoded");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRD || state_q == S_CWR) |-> (w_q <= r_q))
    else $error("compaction write ahead of read");
`endif

endmodule

[rtl/glvs_vote_mem.sv]
// ----------------------------------------------------------------------------
// glvs_vote_mem
// Vote window storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glvs_vote_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[rtl/glvs_div.sv]
// ----------------------------------------------------------------------------
// glvs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glvs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [glvs_pkg::DIV_W-1:0] dividend_i,
  input  logic [glvs_pkg::DIV_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [glvs_pkg::DIV_W-1:0] quot_o
);

  localparam int W  = glvs_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic          run_q, run_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  div_q, div_d;
  logic [W:0]    rem_sh;

  assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
  assign done_o = run_q && (cnt_q == CW'(W));
  assign quot_o = quo_q;

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    div_d = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
    end else if (run_q) begin
      if (cnt_q == CW'(W)) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CW'(1);
        if (rem_sh >= {1'b0, div_q}) begin
          rem_d = rem_sh - {1'b0, div_q};
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      div_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      div_q <= div_d;
    end
  end

endmodule

[dv/tb_gesture_label_vote_stabilizer.sv]
// ----------------------------------------------------------------------------
// tb_gesture_label_vote_stabilizer
// Self-checking bench: a short directed table, then phases of random frame
// trains under six register settings. Every frame transfer is run through an
// in-bench predictor, and each output transfer is checked field by field
// against the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gesture_label_vote_stabilizer;

  localparam int DEPTH      = 16;
  localparam int LIMIT      = 3000000;
  localparam int N_PHASE    = 6;
  localparam int PER_PHASE  = 80;
  localparam int HOLDOFF    = 1500;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic cfg_valid, cfg_ready;
  logic [glvs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [glvs_pkg::CFG_DATA_W-1:0] cfg_data;
  glvs_pkg::glvs_in_t  in_data;
  glvs_pkg::glvs_out_t out_data;

  gesture_label_vote_stabilizer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // --------------------------------------------------------------------------
  // Predictor: register copy and stabilizer state
  // --------------------------------------------------------------------------
  logic [7:0]         m_rest;
  logic [15:0]        m_horizon, m_step, m_hold;
  logic [16:0]        m_frac;
  logic signed [15:0] m_thr;

  logic [31:0] frames_n, changes_n, last_time, conf_time, elect_time;
  logic        last_time_ok, conf_ok, elect_open;
  logic [7:0]  stable_lbl, shown_lbl;
  logic [1:0]  shown_val;
  int          held;
  logic [31:0] ballot_time [DEPTH];
  logic [7:0]  ballot_lbl  [DEPTH];

  glvs_pkg::glvs_out_t expected_q[$];
  glvs_pkg::glvs_out_t last_pred;
  int        errors, results_seen, frames_sent, resets_sent;
  int        val_hits [3];
  int        cycles = 0;

  function automatic void go_rest();
    held       = 0;
    elect_open = 1'b0;
    stable_lbl = m_rest;
    conf_ok    = 1'b0;
  endfunction

  function automatic glvs_pkg::glvs_out_t report(glvs_pkg::glvs_in_t it, logic [7:0] g,
                                                 logic [1:0] v);
    glvs_pkg::glvs_out_t o;
    if (g != shown_lbl || v != shown_val) changes_n++;
    shown_lbl        = g;
    shown_val        = v;
    o.frame_count    = frames_n;
    o.change_count   = changes_n;
    o.gesture        = g;
    o.validity       = v;
    o.margin_echo    = it.confidence;
    o.time_echo      = it.time_ms;
    o.candidate_echo = it.candidate;
    return o;
  endfunction

  // Drop aged ballots, then append if room remains.
  function automatic void add_ballot(logic [31:0] t, logic [7:0] lbl);
    int w;
    w = 0;
    for (int r = 0; r < held; r++) begin
      if (t - ballot_time[r] <= {16'd0, m_horizon}) begin
        ballot_time[w] = ballot_time[r];
        ballot_lbl[w]  = ballot_lbl[r];
        w++;
      end
    end
    held = w;
    if (held < DEPTH) begin
      ballot_time[held] = t;
      ballot_lbl[held]  = lbl;
      held++;
    end
  endfunction

  function automatic void run_election(logic [31:0] t);
    logic [31:0] step, min_n;
    longint      cnt;
    step  = (m_step == 16'd0) ? 32'd1 : {16'd0, m_step};
    min_n = {16'd0, m_horizon} / step + 32'd1;
    if (!elect_open || held < min_n || (t - elect_time) < {16'd0, m_horizon}) return;
    for (int i = 0; i < held; i++) begin
      cnt = 0;
      for (int j = 0; j < held; j++)
        if (ballot_lbl[j] == ballot_lbl[i]) cnt++;
      if (cnt * 65536 >= longint'(m_frac) * held) begin
        stable_lbl = ballot_lbl[i];
        return;
      end
    end
  endfunction

  // Returns 1 and the expected result when the frame produces one.
  function automatic bit stabilize(glvs_pkg::glvs_in_t it, output glvs_pkg::glvs_out_t o);
    bit keep;
    o = '0;
    if (it.mode) begin
      go_rest();
      last_time_ok = 1'b0;
      shown_lbl    = m_rest;
      shown_val    = glvs_pkg::VAL_OK;
      return 1'b0;
    end
    frames_n++;
    if (last_time_ok && it.time_ms < last_time) begin
      go_rest();
      last_time_ok = 1'b0;
      o = report(it, m_rest, glvs_pkg::VAL_SIGNAL);
      return 1'b1;
    end
    last_time    = it.time_ms;
    last_time_ok = 1'b1;
    if (!it.signal_ok) begin
      go_rest();
      o = report(it, m_rest, glvs_pkg::VAL_SIGNAL);
      return 1'b1;
    end
    if (it.confidence < m_thr) begin
      keep = conf_ok && (it.time_ms - conf_time <= {16'd0, m_hold});
      if (!keep) go_rest();
      o = report(it, keep ? stable_lbl : m_rest, glvs_pkg::VAL_LOWCONF);
      return 1'b1;
    end
    conf_time = it.time_ms;
    conf_ok   = 1'b1;
    if (!elect_open) begin
      elect_time = it.time_ms;
      elect_open = 1'b1;
    end
    add_ballot(it.time_ms, it.candidate);
    run_election(it.time_ms);
    o = report(it, stable_lbl, glvs_pkg::VAL_OK);
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Output checking at the rising edge
  // --------------------------------------------------------------------------
  task automatic field_chk(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    glvs_pkg::glvs_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        field_chk("frame_count", e.frame_count, out_data.frame_count);
        field_chk("change_count", e.change_count, out_data.change_count);
        field_chk("gesture", e.gesture, out_data.gesture);
        field_chk("validity", e.validity, out_data.validity);
        field_chk("margin_echo", e.margin_echo, out_data.margin_echo);
        field_chk("time_echo", e.time_echo, out_data.time_echo);
        field_chk("candidate_echo", e.candidate_echo, out_data.candidate_echo);
        if (out_data.validity < 3) val_hits[out_data.validity]++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
      $display("FAIL gesture_label_vote_stabilizer");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall density is redrawn each time the seg counter wraps; a
  // requested hold-off keeps stall high for a long, self-counted stretch.
  // --------------------------------------------------------------------------
  int hold_req, hold_taken;

  always @(negedge clk) begin
    int left, density, seg;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (left > 0) begin
      left--;
      out_stall <= 1'b1;
    end else if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      left       = HOLDOFF;
      out_stall  <= 1'b1;
    end else begin
      seg++;
      if (seg >= 64) begin
        seg     = 0;
        density = $urandom_range(0, 3) * 25;
      end
      out_stall <= ($urandom_range(0, 99) < density);
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register writes
  // --------------------------------------------------------------------------
  int burst_left;

  // Offer one frame; valid stays up between frames inside a burst.
  task automatic send_frame(glvs_pkg::glvs_in_t it);
    glvs_pkg::glvs_out_t o;
    int        gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (stabilize(it, o)) begin
      expected_q.push_back(o);
      last_pred = o;
    end
    if (it.mode) resets_sent++;
    else frames_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap        = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // a trailing continuity reset may still be in flight
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [glvs_pkg::CFG_IDX_W-1:0] idx,
                           logic [glvs_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      glvs_pkg::CFG_REST_LABEL:   m_rest    = val[7:0];
      glvs_pkg::CFG_VOTE_HORIZON: m_horizon = val[15:0];
      glvs_pkg::CFG_NOMINAL_STEP: m_step    = val[15:0];
      glvs_pkg::CFG_REQ_FRACTION: m_frac    = val;
      glvs_pkg::CFG_MARGIN_THR:   m_thr     = val[15:0];
      glvs_pkg::CFG_HOLD_TIME:    m_hold    = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  typedef struct {
    glvs_pkg::glvs_in_t it;
    bit                 chk;
    logic [7:0]         g;
    logic [1:0]         v;
  } dir_row_t;

  // register settings per phase (rest, horizon, step, fraction, threshold, hold) and frame spacing
  typedef struct {
    int rest, horizon, step, frac, thr, hold, spacing;
  } phase_t;

  logic [31:0] t_now;
  logic [7:0]  lead_lbl;

  function automatic glvs_pkg::glvs_in_t make_frame(int spacing);
    glvs_pkg::glvs_in_t it;
    int                 kind, lo;
    logic [63:0]        raw;
    kind         = $urandom_range(0, 99);
    it.mode      = 1'b0;
    it.signal_ok = 1'b1;
    if ($urandom_range(0, 19) == 0) lead_lbl = 8'($urandom);
    it.candidate  = ($urandom_range(0, 3) != 0) ? lead_lbl : 8'($urandom_range(0, 3));
    lo            = int'(m_thr);
    it.confidence = 16'(lo + int'($urandom_range(0, 32767 - lo)));
    t_now         = t_now + $urandom_range(1, 2 * spacing);
    it.time_ms    = t_now;
    if (kind >= 75 && kind < 83 && lo > -32768) begin
      it.confidence = 16'(lo - 1 - int'($urandom_range(0, lo + 32767)));
    end else if (kind >= 83 && kind < 88) begin
      it.signal_ok = 1'b0;
    end else if (kind >= 88 && kind < 92) begin
      it.time_ms = t_now - $urandom_range(1, 500);
    end else if (kind >= 92 && kind < 96) begin
      it.mode = 1'b1;
    end else if (kind >= 96) begin
      raw   = {$urandom, $urandom};
      it    = raw[$bits(glvs_pkg::glvs_in_t)-1:0];
      t_now = it.time_ms;
    end
    return it;
  endfunction

  initial begin
    dir_row_t           dir[$];
    dir_row_t           row;
    phase_t             ph[N_PHASE];
    glvs_pkg::glvs_in_t it;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors = 0; results_seen = 0; frames_sent = 0; resets_sent = 0;
    hold_req = 0; hold_taken = 0; burst_left = 0;
    val_hits = '{0, 0, 0};
    last_pred = '0;

    m_rest    = glvs_pkg::RST_REST_LABEL;
    m_horizon = glvs_pkg::RST_VOTE_HORIZON;
    m_step    = glvs_pkg::RST_NOMINAL_STEP;
    m_frac    = glvs_pkg::RST_REQ_FRACTION;
    m_thr     = glvs_pkg::RST_MARGIN_THR;
    m_hold    = glvs_pkg::RST_HOLD_TIME;
    frames_n = '0; changes_n = '0; last_time = '0; conf_time = '0; elect_time = '0;
    last_time_ok = 1'b0; conf_ok = 1'b0; elect_open = 1'b0; held = 0;
    stable_lbl = m_rest; shown_lbl = m_rest; shown_val = glvs_pkg::VAL_OK;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table, reset register values. Typed rows: first vote (rest
    // reported), backward time, bad signal, low confidence with no hold.
    row = '{it: '{1'b0, 32'd100, 8'd5, 16'sd256, 1'b1}, chk: 1, g: 8'd0,
            v: glvs_pkg::VAL_OK};
    dir.push_back(row);
    row = '{it: '{1'b0, 32'd50, 8'd5, 16'sd256, 1'b1}, chk: 1, g: 8'd0,
            v: glvs_pkg::VAL_SIGNAL};
    dir.push_back(row);
    row = '{it: '{1'b0, 32'd60, 8'd9, 16'sd256, 1'b0}, chk: 1, g: 8'd0,
            v: glvs_pkg::VAL_SIGNAL};
    dir.push_back(row);
    row = '{it: '{1'b0, 32'd70, 8'd9, -16'sd32768, 1'b1}, chk: 1, g: 8'd0,
            v: glvs_pkg::VAL_LOWCONF};
    dir.push_back(row);
    row = '{it: '{1'b1, 32'd0, 8'd0, 16'sd0, 1'b0}, chk: 0, g: 8'd0,
            v: glvs_pkg::VAL_OK};
    dir.push_back(row);
    // vote train that matures the election on label 255
    for (int k = 0; k < 13; k++) begin
      row = '{it: '{1'b0, 32'(1000 + 20 * k), 8'hFF, 16'sd32767, 1'b1},
              chk: 0, g: 8'd0, v: glvs_pkg::VAL_OK};
      dir.push_back(row);
    end
    // low confidence inside the hold window, then timestamp at the top
    row = '{it: '{1'b0, 32'd1290, 8'd1, 16'sd127, 1'b1}, chk: 0, g: 8'd0,
            v: glvs_pkg::VAL_OK};
    dir.push_back(row);
    row = '{it: '{1'b0, 32'hFFFF_FFFF, 8'd0, 16'sd128, 1'b1}, chk: 0, g: 8'd0,
            v: glvs_pkg::VAL_OK};
    dir.push_back(row);
    row = '{it: '{1'b1, 32'hFFFF_FFFF, 8'hFF, -16'sd1, 1'b1}, chk: 0, g: 8'd0,
            v: glvs_pkg::VAL_OK};
    dir.push_back(row);
    row = '{it: '{1'b0, 32'd0, 8'h5A, 16'sd0, 1'b1}, chk: 1, g: 8'd0,
            v: glvs_pkg::VAL_LOWCONF};
    dir.push_back(row);

    foreach (dir[i]) begin
      if (dir[i].chk && !dir[i].it.mode) begin
        // the predictor must agree with the hand-computed label
        send_frame(dir[i].it);
        if (last_pred.gesture != dir[i].g || last_pred.validity != dir[i].v) begin
          $display("%0t: directed row %0d, expected %0d/%0d, actual %0d/%0d", $time, i,
                   dir[i].g, dir[i].v, last_pred.gesture, last_pred.validity);
          errors++;
        end
      end else begin
        send_frame(dir[i].it);
      end
    end
    drain();

    ph[0] = '{0, 200, 20, 39322, 128, 100, 20};
    ph[1] = '{255, 60, 5, 32768, 0, 65535, 5};
    ph[2] = '{0, 0, 0, 0, -32768, 0, 3};
    ph[3] = '{8'hA5, 65535, 65535, 65536, 32767, 50, 20};
    ph[4] = '{3, 100, 10, 131071, -256, 30, 10};
    ph[5] = '{1, 300, 20, 45000, 64, 120, 10};

    t_now    = 32'd5000;
    lead_lbl = 8'd7;
    for (int p = 0; p < N_PHASE; p++) begin
      if (p != 0) begin
        write_reg(glvs_pkg::CFG_REST_LABEL,   17'(ph[p].rest));
        write_reg(glvs_pkg::CFG_VOTE_HORIZON, 17'(ph[p].horizon));
        write_reg(glvs_pkg::CFG_NOMINAL_STEP, 17'(ph[p].step));
        write_reg(glvs_pkg::CFG_REQ_FRACTION, 17'(ph[p].frac));
        write_reg(glvs_pkg::CFG_MARGIN_THR,   17'(ph[p].thr & 16'hFFFF));
        write_reg(glvs_pkg::CFG_HOLD_TIME,    17'(ph[p].hold));
      end
      for (int n = 0; n < PER_PHASE; n++) begin
        // long receiver hold-off while frames keep coming
        if (p == 5 && n == 10) hold_req++;
        it = make_frame(ph[p].spacing);
        send_frame(it);
      end
      drain();
    end

    repeat (400) @(posedge clk);
    $display("covered %0d frames, %0d continuity resets, 6 register settings",
             frames_sent, resets_sent);
    $display("results checked %0d: valid %0d, signal invalid %0d, low confidence %0d",
             results_seen, val_hits[0], val_hits[1], val_hits[2]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS gesture_label_vote_stabilizer");
    end else begin
      $display("FAIL gesture_label_vote_stabilizer");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/glvs_pkg.sv
rtl/glvs_vote_mem.sv
rtl/glvs_div.sv
rtl/gesture_label_vote_stabilizer.sv
dv/tb_gesture_label_vote_stabilizer.sv
